// File: rtl/bcu_pkg.sv
// Shared constants for the barycentric coordinates unit.
package bcu_pkg;
  localparam int WEIGHT_W = 32;              // result weight width
  localparam int QUOT_BITS = WEIGHT_W + 1;   // quotient bits resolved by the divider
  localparam int DOT_LAT = 3;                // edge, product and sum stages
  localparam int CRAMER_LAT = 2;             // product and difference stages
  localparam int DIV_LAT = QUOT_BITS + 2;    // setup, one stage per bit, clip
  localparam int OUT_LAT = 1;                // final weight stage
endpackage

// File: rtl/barycentric_coordinates_unit.sv
// Top level of the barycentric coordinates unit.
// Pipelined barycentric weights of a point against a triangle. One transaction
// may be started every clock cycle (busy is never raised); each result appears
// on the result ports with done high for exactly one cycle, after passing through
// 3 dot-product stages, 2 Cramer stages, 35 divider stages and 1 output
// stage with the default settings. The divider resolves one quotient bit per
// stage, which sets the depth. Results cannot be held off, so the receiver must
// take every one. Weights are signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero and clipped to 32 bits; saturated marks a clip. A
// degenerate triangle gives degenerate=1 and all weights zero.
module barycentric_coordinates_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] corner_x_x,
  input  logic signed [COORD_WIDTH-1:0] corner_x_y,
  input  logic signed [COORD_WIDTH-1:0] corner_x_z,
  input  logic signed [COORD_WIDTH-1:0] corner_y_x,
  input  logic signed [COORD_WIDTH-1:0] corner_y_y,
  input  logic signed [COORD_WIDTH-1:0] corner_y_z,
  input  logic signed [COORD_WIDTH-1:0] corner_z_x,
  input  logic signed [COORD_WIDTH-1:0] corner_z_y,
  input  logic signed [COORD_WIDTH-1:0] corner_z_z,
  output logic                          done,
  output logic signed [bcu_pkg::WEIGHT_W-1:0] weight_second,
  output logic signed [bcu_pkg::WEIGHT_W-1:0] weight_third,
  output logic signed [bcu_pkg::WEIGHT_W-1:0] weight_first,
  output logic                          degenerate,
  output logic                          saturated
);
  import bcu_pkg::*;

  localparam int DW  = 2 * (COORD_WIDTH + 1) + 2;  // dot product width
  localparam int NW  = 2 * DW + 1;                 // numerator / denominator width
  localparam int XW  = WEIGHT_W + 2;               // weight_first before clip
  localparam int LAT = DOT_LAT + CRAMER_LAT + DIV_LAT + OUT_LAT;

  // Fully pipelined, receiver cannot stall: never busy.
  assign busy = 1'b0;

  logic                 dot_valid;
  logic signed [DW-1:0] d00, d01, d11, d20, d21;

  bcu_dot #(.CW(COORD_WIDTH), .DW(DW)) u_dot (
    .clk, .rst,
    .in_valid (start && !busy),
    .p_x (point_x), .p_y (point_y), .p_z (point_z),
    .a_x (corner_x_x), .a_y (corner_x_y), .a_z (corner_x_z),
    .b_x (corner_y_x), .b_y (corner_y_y), .b_z (corner_y_z),
    .c_x (corner_z_x), .c_y (corner_z_y), .c_z (corner_z_z),
    .out_valid (dot_valid),
    .d00, .d01, .d11, .d20, .d21
  );

  logic                 cr_valid;
  logic signed [NW-1:0] num0, num1, den;
  logic                 den_zero;

  bcu_cramer #(.DW(DW), .NW(NW)) u_cramer (
    .clk, .rst,
    .in_valid (dot_valid),
    .d00, .d01, .d11, .d20, .d21,
    .out_valid (cr_valid),
    .num0, .num1, .den, .den_zero
  );

  // Two dividers in lockstep; the degenerate flag rides along as a tag.
  logic                       dv0_valid, dv1_valid, dv0_tag, dv1_tag, clip0, clip1;
  logic signed [WEIGHT_W-1:0] wy, wz;

  bcu_div #(.NW(NW), .FRAC(FRAC_BITS)) u_div_second (
    .clk, .rst,
    .in_valid (cr_valid), .in_tag (den_zero),
    .num (num0), .den (den),
    .out_valid (dv0_valid), .out_tag (dv0_tag),
    .quot (wy), .clip (clip0)
  );

  bcu_div #(.NW(NW), .FRAC(FRAC_BITS)) u_div_third (
    .clk, .rst,
    .in_valid (cr_valid), .in_tag (den_zero),
    .num (num1), .den (den),
    .out_valid (dv1_valid), .out_tag (dv1_tag),
    .quot (wz), .clip (clip1)
  );

  // weight_first = one - wy - wz, clipped to 32 bits (signed compares).
  logic signed [XW-1:0] wx_full;
  logic                 wx_hi, wx_lo;
  logic signed [WEIGHT_W-1:0] wx;

  assign wx_full = (XW'(1) <<< FRAC_BITS) - XW'(wy) - XW'(wz);
  assign wx_hi = wx_full > $signed(XW'({1'b0, {(WEIGHT_W-1){1'b1}}}));
  assign wx_lo = wx_full < -(XW'(1) <<< (WEIGHT_W - 1));

  always_comb begin
    priority if (wx_hi) begin
      wx = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else if (wx_lo) begin
      wx = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      wx = WEIGHT_W'(wx_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      degenerate <= 1'b0;
      saturated  <= 1'b0;
    end else begin
      done       <= dv0_valid && dv1_valid;
      degenerate <= dv0_valid && dv0_tag;
      saturated  <= dv0_valid && !dv0_tag && (clip0 || clip1 || wx_hi || wx_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (dv1_tag) begin
      weight_second <= '0;
      weight_third  <= '0;
      weight_first  <= '0;
    end else begin
      weight_second <= wy;
      weight_third  <= wz;
      weight_first  <= wx;
    end
  end

`ifndef ASSERT_OFF
  // Each start yields a done strobe once it has passed through every pipeline stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(!rst, LAT) |-> (done == $past(start, LAT)))
    else $error("result strobe out of step with start");

  // Degenerate triangles report zero weights and no clip.
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    degenerate |-> (done && !saturated && weight_second == '0 &&
                    weight_third == '0 && weight_first == '0))
    else $error("degenerate result not cleared");

  // Without clipping, the three weights sum to one.
  a_sum: assert property (@(posedge clk) disable iff (rst)
    (done && !saturated && !degenerate) |->
      (weight_first == WEIGHT_W'((WEIGHT_W'(1) << FRAC_BITS) - weight_second - weight_third)))
    else $error("weights do not sum to one");
`endif
endmodule

// File: rtl/bcu_dot.sv
// Edge vectors and the five dot products, three pipeline stages.
module bcu_dot #(
  parameter int CW = 16,
  parameter int DW = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] p_x, p_y, p_z,
  input  logic signed [CW-1:0] a_x, a_y, a_z,
  input  logic signed [CW-1:0] b_x, b_y, b_z,
  input  logic signed [CW-1:0] c_x, c_y, c_z,
  output logic                 out_valid,
  output logic signed [DW-1:0] d00, d01, d11, d20, d21
);
  import bcu_pkg::*;

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;

  logic [2:0] valid;
  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] p00 [3];
  logic signed [PW-1:0] p01 [3];
  logic signed [PW-1:0] p11 [3];
  logic signed [PW-1:0] p20 [3];
  logic signed [PW-1:0] p21 [3];
  logic signed [CW-1:0] pin [3];
  logic signed [CW-1:0] ain [3];
  logic signed [CW-1:0] bin [3];
  logic signed [CW-1:0] cin [3];

  assign pin = '{p_x, p_y, p_z};
  assign ain = '{a_x, a_y, a_z};
  assign bin = '{b_x, b_y, b_z};
  assign cin = '{c_x, c_y, c_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e0[k] <= EW'(bin[k]) - EW'(ain[k]);
      e1[k] <= EW'(cin[k]) - EW'(ain[k]);
      e2[k] <= EW'(pin[k]) - EW'(ain[k]);
      p00[k] <= PW'(e0[k]) * PW'(e0[k]);
      p01[k] <= PW'(e0[k]) * PW'(e1[k]);
      p11[k] <= PW'(e1[k]) * PW'(e1[k]);
      p20[k] <= PW'(e2[k]) * PW'(e0[k]);
      p21[k] <= PW'(e2[k]) * PW'(e1[k]);
    end
    d00 <= DW'(p00[0]) + DW'(p00[1]) + DW'(p00[2]);
    d01 <= DW'(p01[0]) + DW'(p01[1]) + DW'(p01[2]);
    d11 <= DW'(p11[0]) + DW'(p11[1]) + DW'(p11[2]);
    d20 <= DW'(p20[0]) + DW'(p20[1]) + DW'(p20[2]);
    d21 <= DW'(p21[0]) + DW'(p21[1]) + DW'(p21[2]);
  end

  assign out_valid = valid[DOT_LAT-1];
endmodule

// File: rtl/bcu_cramer.sv
// Cramer's rule numerators and denominator, two pipeline stages.
module bcu_cramer #(
  parameter int DW = 36,
  parameter int NW = 73
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] d00, d01, d11, d20, d21,
  output logic                 out_valid,
  output logic signed [NW-1:0] num0,
  output logic signed [NW-1:0] num1,
  output logic signed [NW-1:0] den,
  output logic                 den_zero
);
  import bcu_pkg::*;

  localparam int MW = 2 * DW;

  logic [1:0] valid;
  logic signed [MW-1:0] m_00_11, m_01_01, m_11_20, m_01_21, m_00_21, m_01_20;
  logic signed [NW-1:0] den_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[0], in_valid};
    end
  end

  assign den_c = NW'(m_00_11) - NW'(m_01_01);

  always_ff @(posedge clk) begin
    m_00_11 <= MW'(d00) * MW'(d11);
    m_01_01 <= MW'(d01) * MW'(d01);
    m_11_20 <= MW'(d11) * MW'(d20);
    m_01_21 <= MW'(d01) * MW'(d21);
    m_00_21 <= MW'(d00) * MW'(d21);
    m_01_20 <= MW'(d01) * MW'(d20);
    num0 <= NW'(m_11_20) - NW'(m_01_21);
    num1 <= NW'(m_00_21) - NW'(m_01_20);
    den <= den_c;
    den_zero <= (den_c == '0);
  end

  assign out_valid = valid[CRAMER_LAT-1];
endmodule

// File: rtl/bcu_div.sv
// Pipelined restoring divider: one quotient bit per stage, truncation and clip to 32 bits.
module bcu_div #(
  parameter int NW = 73,
  parameter int FRAC = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_tag,
  input  logic signed [NW-1:0]        num,
  input  logic        [NW-1:0]        den,
  output logic                        out_valid,
  output logic                        out_tag,
  output logic signed [bcu_pkg::WEIGHT_W-1:0] quot,
  output logic                        clip
);
  import bcu_pkg::*;

  localparam int RW = NW + FRAC + QUOT_BITS + 1;

  logic [QUOT_BITS:0]   valid;
  logic [QUOT_BITS:0]   tag;
  logic [QUOT_BITS:0]   neg;
  logic [QUOT_BITS:0]   ovf;
  logic [RW-1:0]        rem  [QUOT_BITS+1];
  logic [NW-1:0]        dsr  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] qb   [QUOT_BITS+1];
  logic [NW-1:0]        mag;
  logic [RW-1:0]        dividend;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign dividend = RW'(mag) << FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= in_tag;
    neg[0] <= num[NW-1];
    ovf[0] <= dividend >= (RW'(den) << QUOT_BITS);
    rem[0] <= dividend;
    dsr[0] <= den;
    qb[0]  <= '0;
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    localparam int SH = QUOT_BITS - 1 - k;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(dsr[k]) << SH;
    assign take = rem[k] >= dsh;
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
    end
    always_ff @(posedge clk) begin
      tag[k+1] <= tag[k];
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
      dsr[k+1] <= dsr[k];
      rem[k+1] <= take ? rem[k] - dsh : rem[k];
      qb[k+1]  <= {qb[k][QUOT_BITS-2:0], take};
    end
  end

  // Clip: magnitude limit is 2^31-1 for positive, 2^31 for negative results.
  logic [QUOT_BITS-1:0] q;
  logic                 big;
  assign q = qb[QUOT_BITS];
  assign big = ovf[QUOT_BITS] ||
               (neg[QUOT_BITS] ? (q > (QUOT_BITS'(1) << (WEIGHT_W - 1)))
                               : (q > ((QUOT_BITS'(1) << (WEIGHT_W - 1)) - QUOT_BITS'(1))));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_tag <= tag[QUOT_BITS];
    clip <= big;
    if (big) begin
      quot <= neg[QUOT_BITS] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      quot <= neg[QUOT_BITS] ? WEIGHT_W'(-q) : WEIGHT_W'(q);
    end
  end
endmodule
